// ----- rtl/e2rt_pkg.sv -----
// Package holding the transfer types, CORDIC constants and helper functions for the pose block.
package e2rt_pkg;

    localparam int CORDIC_STAGES = 14;
    localparam int ATAN_ENTRIES = 24;
    localparam int RUN_STAGES = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int CW = 34;
    localparam int SW = (RUN_STAGES > 1) ? $clog2(RUN_STAGES) : 1;

    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_INV    = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] rot_r0c0;
        logic signed [15:0] rot_r0c1;
        logic signed [15:0] rot_r0c2;
        logic signed [15:0] rot_r1c0;
        logic signed [15:0] rot_r1c1;
        logic signed [15:0] rot_r1c2;
        logic signed [15:0] rot_r2c0;
        logic signed [15:0] rot_r2c1;
        logic signed [15:0] rot_r2c2;
        logic signed [31:0] out_shift_x;
        logic signed [31:0] out_shift_y;
        logic signed [31:0] out_shift_z;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } t_rot;

    typedef struct packed {
        t_rot [2:0]  rot;
        logic [95:0] shift;
    } t_cell;

    function automatic logic signed [CW-1:0] atan_q30(input logic [SW-1:0] i);
        logic signed [CW-1:0] v;
        case (int'(i))
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            default: v = 34'sd1 <<< (30 - int'(i));
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< 45)) >>> 46;
        if (r > 64'sd16384) r = 64'sd16384;
        if (r < -64'sd16384) r = -64'sd16384;
        return r[15:0];
    endfunction

endpackage

// ----- rtl/euler_to_rigid_transform.sv -----
// Top level: pose vector to rotation matrix and translation.
// The input channel takes one pose per transfer (i_in_valid, o_in_stall) and the
// output channel gives one transform per transfer (o_out_valid, i_out_stall).
// Roll, pitch and yaw go together through one row of CORDIC cells, one cell per stage,
// followed by three register steps that form, round and saturate the nine entries.
// From input transfer to output valid an item passes one range-reduction register,
// the cell row and three matrix registers.
// Throughput is one transfer per cycle while the output is not stalled; the whole pipeline advances as one.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_in_stall rises in the same cycle, even where earlier stages hold empty slots.
// Reset clears the valid bits of every stage; payload registers are not reset.
// The translation passes through alongside the matrix unchanged.
module euler_to_rigid_transform (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  e2rt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output e2rt_pkg::t_out o_out_data
);
    localparam int DEPTH = e2rt_pkg::RUN_STAGES + 4;

    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic             w_en;
    e2rt_pkg::t_cell  r_pre;
    e2rt_pkg::t_cell  n_pre;
    e2rt_pkg::t_cell  w_chain [e2rt_pkg::RUN_STAGES+1];
    logic signed [e2rt_pkg::CW-1:0] w_s [3];
    logic signed [e2rt_pkg::CW-1:0] w_c [3];
    logic signed [e2rt_pkg::CW-1:0] w_z;
    logic [15:0] w_ang [3];

    assign w_en = !(r_vld[DEPTH-1] && i_out_stall);
    assign o_in_stall = !w_en;
    assign o_out_valid = r_vld[DEPTH-1];

    always_comb begin
        w_ang[0] = i_in_data.roll_angle;
        w_ang[1] = i_in_data.pitch_angle;
        w_ang[2] = i_in_data.yaw_angle;
        n_pre.shift = {i_in_data.shift_x, i_in_data.shift_y, i_in_data.shift_z};
        w_z = '0;
        for (int k = 0; k < 3; k++) begin
            w_z = e2rt_pkg::CW'($signed(w_ang[k])) <<< 17;
            n_pre.rot[k].x = e2rt_pkg::GAIN_INV;
            n_pre.rot[k].y = '0;
            n_pre.rot[k].flip = 1'b0;
            n_pre.rot[k].z = w_z;
            if (w_z > e2rt_pkg::HALF_PI_Q30) begin
                n_pre.rot[k].z = w_z - e2rt_pkg::PI_Q30;
                n_pre.rot[k].flip = 1'b1;
            end else if (w_z < -e2rt_pkg::HALF_PI_Q30) begin
                n_pre.rot[k].z = w_z + e2rt_pkg::PI_Q30;
                n_pre.rot[k].flip = 1'b1;
            end
        end
        n_vld = {r_vld[DEPTH-2:0], i_in_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_pre <= n_pre;
    end

    assign w_chain[0] = r_pre;

    for (genvar g = 0; g < e2rt_pkg::RUN_STAGES; g++) begin : g_cell
        e2rt_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_stage (e2rt_pkg::SW'(g)),
            .i_d     (w_chain[g]),
            .o_q     (w_chain[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_s[k] = w_chain[e2rt_pkg::RUN_STAGES].rot[k].flip ?
                     -w_chain[e2rt_pkg::RUN_STAGES].rot[k].y :
                      w_chain[e2rt_pkg::RUN_STAGES].rot[k].y;
            w_c[k] = w_chain[e2rt_pkg::RUN_STAGES].rot[k].flip ?
                     -w_chain[e2rt_pkg::RUN_STAGES].rot[k].x :
                      w_chain[e2rt_pkg::RUN_STAGES].rot[k].x;
        end
    end

    e2rt_mat u_mat (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_s     (w_s),
        .i_c     (w_c),
        .i_shift (w_chain[e2rt_pkg::RUN_STAGES].shift),
        .o_q     (o_out_data)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output stall");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall && !i_in_valid |=> !r_vld[0])
        else $error("bubble not tracked");
endmodule

// ----- rtl/e2rt_cell.sv -----
// One CORDIC rotation cell acting on all three angles of an item.
module e2rt_cell (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [e2rt_pkg::SW-1:0] i_stage,
    input  e2rt_pkg::t_cell        i_d,
    output e2rt_pkg::t_cell        o_q
);
    e2rt_pkg::t_cell n_q;
    e2rt_pkg::t_cell r_q;
    logic signed [e2rt_pkg::CW-1:0] w_at;

    always_comb begin
        w_at = e2rt_pkg::atan_q30(i_stage);
        n_q = i_d;
        for (int k = 0; k < 3; k++) begin
            if (!i_d.rot[k].z[e2rt_pkg::CW-1]) begin
                n_q.rot[k].x = i_d.rot[k].x - (i_d.rot[k].y >>> i_stage);
                n_q.rot[k].y = i_d.rot[k].y + (i_d.rot[k].x >>> i_stage);
                n_q.rot[k].z = i_d.rot[k].z - w_at;
            end else begin
                n_q.rot[k].x = i_d.rot[k].x + (i_d.rot[k].y >>> i_stage);
                n_q.rot[k].y = i_d.rot[k].y - (i_d.rot[k].x >>> i_stage);
                n_q.rot[k].z = i_d.rot[k].z + w_at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_q <= n_q;
    end

    assign o_q = r_q;
endmodule

// ----- rtl/e2rt_mat.sv -----
// Matrix stage: products of sines and cosines, rounding and saturation, three register steps.
module e2rt_mat (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [e2rt_pkg::CW-1:0] i_s [3],
    input  logic signed [e2rt_pkg::CW-1:0] i_c [3],
    input  logic [95:0]                   i_shift,
    output e2rt_pkg::t_out                o_q
);
    logic signed [63:0] r_cysp, r_sysp, r_cycp, r_sycp, r_cpsr, r_cpcr;
    logic signed [63:0] r_sycr, r_sysr, r_cycr, r_cysr;
    logic signed [31:0] r_sr, r_cr, r_sp;
    logic [95:0] r_sh1, r_sh2;
    logic signed [63:0] r_m [9];
    logic signed [63:0] w_a, w_b;
    logic signed [31:0] w_cysp, w_sysp;

    always_comb begin
        w_a = r_cysp + (64'sd1 <<< 29);
        w_b = r_sysp + (64'sd1 <<< 29);
        w_cysp = 32'(w_a >>> 30);
        w_sysp = 32'(w_b >>> 30);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cysp <= 64'(i_c[2]) * 64'(i_s[1]);
            r_sysp <= 64'(i_s[2]) * 64'(i_s[1]);
            r_cycp <= 64'(i_c[2]) * 64'(i_c[1]);
            r_sycp <= 64'(i_s[2]) * 64'(i_c[1]);
            r_cpsr <= 64'(i_c[1]) * 64'(i_s[0]);
            r_cpcr <= 64'(i_c[1]) * 64'(i_c[0]);
            r_sycr <= 64'(i_s[2]) * 64'(i_c[0]);
            r_sysr <= 64'(i_s[2]) * 64'(i_s[0]);
            r_cycr <= 64'(i_c[2]) * 64'(i_c[0]);
            r_cysr <= 64'(i_c[2]) * 64'(i_s[0]);
            r_sr <= 32'(i_s[0]);
            r_cr <= 32'(i_c[0]);
            r_sp <= 32'(i_s[1]);
            r_sh1 <= i_shift;

            r_m[0] <= r_cycp;
            r_m[1] <= 64'(w_cysp) * 64'(r_sr) - r_sycr;
            r_m[2] <= 64'(w_cysp) * 64'(r_cr) + r_sysr;
            r_m[3] <= r_sycp;
            r_m[4] <= 64'(w_sysp) * 64'(r_sr) + r_cycr;
            r_m[5] <= 64'(w_sysp) * 64'(r_cr) - r_cysr;
            r_m[6] <= -(64'(r_sp) <<< 30);
            r_m[7] <= r_cpsr;
            r_m[8] <= r_cpcr;
            r_sh2 <= r_sh1;

            o_q.rot_r0c0 <= e2rt_pkg::to_q14(r_m[0]);
            o_q.rot_r0c1 <= e2rt_pkg::to_q14(r_m[1]);
            o_q.rot_r0c2 <= e2rt_pkg::to_q14(r_m[2]);
            o_q.rot_r1c0 <= e2rt_pkg::to_q14(r_m[3]);
            o_q.rot_r1c1 <= e2rt_pkg::to_q14(r_m[4]);
            o_q.rot_r1c2 <= e2rt_pkg::to_q14(r_m[5]);
            o_q.rot_r2c0 <= e2rt_pkg::to_q14(r_m[6]);
            o_q.rot_r2c1 <= e2rt_pkg::to_q14(r_m[7]);
            o_q.rot_r2c2 <= e2rt_pkg::to_q14(r_m[8]);
            o_q.out_shift_x <= r_sh2[95:64];
            o_q.out_shift_y <= r_sh2[63:32];
            o_q.out_shift_z <= r_sh2[31:0];
        end
    end
endmodule

// ----- sim/euler_to_rigid_transform_tb.sv -----
// Testbench for the pose block: random and directed poses checked against a predictor.
module euler_to_rigid_transform_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = e2rt_pkg::CORDIC_STAGES + 4;
    localparam longint PI_C = 64'sd3373259426;
    localparam longint HALF_PI_C = 64'sd1686629713;
    localparam longint GAIN_C = 64'sd652032874;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    e2rt_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    e2rt_pkg::t_out o_out_data;

    e2rt_pkg::t_out pending_transforms[$];
    int mismatch_count = 0;
    int transforms_seen = 0;
    int poses_sent = 0;
    bit calm = 1'b0;

    euler_to_rigid_transform dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_entry(int i);
        longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return tbl[i];
        return 64'sd1 <<< (30 - i);
    endfunction

    function automatic void angle_sin_cos(input logic signed [15:0] code,
                                          output longint s, output longint c);
        longint z, x, y, nx;
        bit flip;
        z = longint'(code) * 131072;
        x = GAIN_C;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_C) begin
            z -= PI_C;
            flip = 1'b1;
        end else if (z < -HALF_PI_C) begin
            z += PI_C;
            flip = 1'b1;
        end
        for (int i = 0; i < e2rt_pkg::CORDIC_STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_sh(y, i);
                y = y + floor_sh(x, i);
                z -= arctan_entry(i);
            end else begin
                nx = x + floor_sh(y, i);
                y = y - floor_sh(x, i);
                z += arctan_entry(i);
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint round_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] sat_q14(longint v);
        longint r;
        r = (v + (64'sd1 <<< 45)) >>> 46;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic e2rt_pkg::t_out predict_transform(e2rt_pkg::t_in p);
        longint sr, cr, sp, cp, sy, cy, cysp, sysp;
        e2rt_pkg::t_out t;
        angle_sin_cos(p.roll_angle, sr, cr);
        angle_sin_cos(p.pitch_angle, sp, cp);
        angle_sin_cos(p.yaw_angle, sy, cy);
        cysp = round_q30(cy, sp);
        sysp = round_q30(sy, sp);
        t.rot_r0c0 = sat_q14(cy * cp);
        t.rot_r0c1 = sat_q14(cysp * sr - sy * cr);
        t.rot_r0c2 = sat_q14(cysp * cr + sy * sr);
        t.rot_r1c0 = sat_q14(sy * cp);
        t.rot_r1c1 = sat_q14(sysp * sr + cy * cr);
        t.rot_r1c2 = sat_q14(sysp * cr - cy * sr);
        t.rot_r2c0 = sat_q14(-sp * (64'sd1 <<< 30));
        t.rot_r2c1 = sat_q14(cp * sr);
        t.rot_r2c2 = sat_q14(cp * cr);
        t.out_shift_x = p.shift_x;
        t.out_shift_y = p.shift_y;
        t.out_shift_z = p.shift_z;
        return t;
    endfunction

    task automatic send_pose(e2rt_pkg::t_in p);
        while (!calm && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_transforms = {pending_transforms, predict_transform(p)};
        poses_sent++;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= (!calm && $urandom_range(99) < 14);
    end

    always @(posedge i_clk) begin
        e2rt_pkg::t_out exp_t;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            transforms_seen++;
            if (pending_transforms.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected transfer %p", o_out_data);
            end else begin
                exp_t = pending_transforms.pop_front();
                if (exp_t !== o_out_data) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", exp_t, o_out_data);
                end
            end
        end
    end

    function automatic logic signed [15:0] any_angle();
        return 16'($urandom);
    endfunction

    function automatic e2rt_pkg::t_in random_pose(bit wide);
        e2rt_pkg::t_in p;
        p.roll_angle = wide ? any_angle() : 16'(int'($urandom_range(51472)) - 25736);
        p.pitch_angle = wide ? any_angle() : 16'(int'($urandom_range(51472)) - 25736);
        p.yaw_angle = wide ? any_angle() : 16'(int'($urandom_range(51472)) - 25736);
        p.shift_x = $urandom;
        p.shift_y = $urandom;
        p.shift_z = $urandom;
        return p;
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_transforms.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extreme_angles();
        logic signed [15:0] codes[8] = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sd12868,
                                         16'sd12869, -16'sd12869, 16'sd25736, -16'sd25736};
        e2rt_pkg::t_in p;
        for (int k = 0; k < 8; k++) begin
            p.roll_angle = codes[k];
            p.pitch_angle = codes[(k + 3) % 8];
            p.yaw_angle = codes[(k + 5) % 8];
            p.shift_x = (k % 2) ? 32'h7fffffff : 32'h80000000;
            p.shift_y = (k % 2) ? 32'h80000000 : 32'hffffffff;
            p.shift_z = 32'(k);
            send_pose(p);
        end
    endtask

    task automatic test_saturating_angles();
        e2rt_pkg::t_in p;
        for (int k = 0; k < 8; k++) begin
            p = '0;
            p.pitch_angle = (k % 2) ? 16'sd12868 : -16'sd12868;
            p.roll_angle = (k < 4) ? 16'sd0 : 16'sd6434;
            p.yaw_angle = 16'(k * 3217);
            send_pose(p);
        end
    endtask

    task automatic test_random_poses();
        for (int n = 0; n < 1330; n++) begin
            calm = (n >= 400 && n < 600);
            send_pose(random_pose($urandom_range(3) == 0));
            if (n == 700) wait_drained();
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extreme_angles();
        test_saturating_angles();
        test_random_poses();
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d poses, %0d transforms checked: angle extremes, range folds,",
                 poses_sent, transforms_seen);
        $display("saturated entries, random wide angles and translations, stalls both sides");
        if (mismatch_count == 0 && pending_transforms.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/e2rt_pkg.sv
rtl/e2rt_cell.sv
rtl/e2rt_mat.sv
rtl/euler_to_rigid_transform.sv
sim/euler_to_rigid_transform_tb.sv
